FILE: sv/mwsa_pkg.sv
// Package for the min-weight server assigner.
// Holds field widths, time limits and the structs shared by the top level and the cells.
// No dependencies.
package mwsa_pkg;

    localparam int TIME_W      = 48;
    localparam int WT_W        = 16;
    localparam int DUR_W       = 16;
    localparam int SLOT_W      = 4;
    localparam int CFG_W       = 5;
    localparam int DEF_SERVERS = 16;

    localparam logic [TIME_W-1:0] TIME_MAX    = {TIME_W{1'b1}};
    localparam logic [CFG_W-1:0]  CFG_RST_VAL = 5'd16;

    // Search token that walks down the row of server cells.
    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] t0;
        logic              any;
        logic [WT_W-1:0]   aw;
        logic              bhas;
        logic [TIME_W-1:0] e;
        logic [WT_W-1:0]   bw;
    } mwsa_tok_t;

    // Write command broadcast to the cells; the selected cell applies it.
    typedef struct packed {
        logic              load;
        logic              set_free;
        logic [WT_W-1:0]   weight;
        logic [TIME_W-1:0] free_val;
    } mwsa_wr_t;

endpackage

FILE: sv/mwsa_cell.sv
// One server cell of the min-weight server assigner: weight and free time of one server.
// Refines the search token and hands it to the next cell each cycle.
// Depends on mwsa_pkg.
module mwsa_cell
    import mwsa_pkg::*;
#(
    parameter int IDX_W = 4,
    parameter int IDX   = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             active,
    input  logic             wr_sel,
    input  mwsa_wr_t         wr,
    input  mwsa_tok_t        tok_in,
    input  logic [IDX_W-1:0] ai_in,
    input  logic [IDX_W-1:0] bi_in,
    output mwsa_tok_t        tok_out,
    output logic [IDX_W-1:0] ai_out,
    output logic [IDX_W-1:0] bi_out
);

    logic [WT_W-1:0]   weight_reg;
    logic [TIME_W-1:0] free_reg;
    mwsa_tok_t         tok_reg;
    mwsa_tok_t         tok_next;
    logic [IDX_W-1:0]  ai_reg;
    logic [IDX_W-1:0]  ai_next;
    logic [IDX_W-1:0]  bi_reg;
    logic [IDX_W-1:0]  bi_next;
    logic              free_le;
    logic              free_lt;
    logic              free_eq;

    assign free_le = (free_reg <= tok_in.t0);
    assign free_lt = (free_reg < tok_in.e);
    assign free_eq = (free_reg == tok_in.e);

    always_comb
    begin
        tok_next = tok_in;
        ai_next  = ai_in;
        bi_next  = bi_in;
        if (active)
        begin
            if (free_le && (!tok_in.any || (weight_reg < tok_in.aw)))
            begin
                tok_next.any = 1'b1;
                tok_next.aw  = weight_reg;
                ai_next      = IDX_W'(IDX);
            end
            if (!tok_in.bhas || free_lt || (free_eq && (weight_reg < tok_in.bw)))
            begin
                tok_next.bhas = 1'b1;
                tok_next.e    = free_reg;
                tok_next.bw   = weight_reg;
                bi_next       = IDX_W'(IDX);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= '0;
            free_reg   <= '0;
            tok_reg    <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (wr_sel && wr.load)
            begin
                weight_reg <= wr.weight;
                free_reg   <= '0;
            end
            else if (wr_sel && wr.set_free)
            begin
                free_reg <= wr.free_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ai_reg <= ai_next;
        bi_reg <= bi_next;
    end

    assign tok_out = tok_reg;
    assign ai_out  = ai_reg;
    assign bi_out  = bi_reg;

endmodule

FILE: sv/min_weight_server_assigner.sv
// Top level of the min-weight server assigner: request handshakes, task clock and the cell row.
// Depends on mwsa_pkg and mwsa_cell.
//
// Channel   Direction  Handshake              Contents
// s_*       in         s_tvalid / s_tready    load command or task request
// m_*       out        m_tvalid / m_tready    assigned server and start time
// cfg_*     in         cfg_valid / cfg_ready  active server count
//
// A load request leaves the block idle, so the next request can follow at once.
// A task request walks the row of NUM_SERVERS cells, one cell per cycle, and passes the start
// register, the cells and the finish registers before the result register; s_tready is low meanwhile.
// A finished search waits while the output register still holds an unaccepted result.
// A finished result waits in the output register while the next request is accepted.
// Reset clears all weights and free times; the active count resets to 16.
module min_weight_server_assigner
    import mwsa_pkg::*;
#(
    parameter int NUM_SERVERS = DEF_SERVERS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [39:0]      s_tdata,   // server_slot[3:0], server_weight[19:4],
                                        // task_duration[35:20], zero pad
    input  logic [0:0]       s_tuser,   // cmd[0]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [55:0]      m_tdata,   // assigned_server[3:0], start_time[51:4], zero pad
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int IDX_W  = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
    localparam int CNT_RAW = $clog2(NUM_SERVERS + 1);
    localparam int CNT_W  = (CNT_RAW > CFG_W) ? CNT_RAW : CFG_W;

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FIN} state_t;

    state_t              state_reg;
    logic [CFG_W-1:0]    cfg_reg;
    logic                start_reg;
    logic [TIME_W-1:0]   t0_reg;
    logic [DUR_W-1:0]    dur_reg;
    logic [TIME_W-1:0]   task_count_reg;
    logic [TIME_W-1:0]   last_start_reg;
    logic [TIME_W-1:0]   fin_t_reg;
    logic [IDX_W-1:0]    fin_idx_reg;
    logic                m_tvalid_reg;
    logic [55:0]         m_tdata_reg;

    logic                in_cmd;
    logic [SLOT_W-1:0]   in_slot;
    logic [WT_W-1:0]     in_weight;
    logic [DUR_W-1:0]    in_dur;
    logic                s_accept;
    logic                slot_ok;
    logic                do_load;
    logic                commit;
    logic [CNT_W-1:0]    cfg_ext;
    logic [CNT_W-1:0]    pool;
    logic [TIME_W-1:0]   t0_next;
    logic [TIME_W:0]     end_sum;
    logic [TIME_W-1:0]   end_time;
    logic [TIME_W-1:0]   count_inc;
    mwsa_wr_t            wr;

    mwsa_tok_t           tok [0:NUM_SERVERS];
    logic [IDX_W-1:0]    ai  [0:NUM_SERVERS];
    logic [IDX_W-1:0]    bi  [0:NUM_SERVERS];
    logic [NUM_SERVERS-1:0] active;
    logic [NUM_SERVERS-1:0] sel;

    assign in_cmd    = s_tuser[0];
    assign in_slot   = s_tdata[3:0];
    assign in_weight = s_tdata[19:4];
    assign in_dur    = s_tdata[35:20];

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign cfg_ext = CNT_W'(cfg_reg);
    assign pool    = (cfg_reg == '0) ? CNT_W'(1) :
                     ((cfg_ext > CNT_W'(NUM_SERVERS)) ? CNT_W'(NUM_SERVERS) : cfg_ext);

    assign slot_ok = (CNT_W'(in_slot) < CNT_W'(NUM_SERVERS));
    assign do_load = s_accept && !in_cmd && slot_ok;
    assign commit  = (state_reg == ST_FIN) && (!m_tvalid_reg || m_tready);

    assign t0_next   = (task_count_reg > last_start_reg) ? task_count_reg : last_start_reg;
    assign end_sum   = {1'b0, fin_t_reg} + (TIME_W + 1)'(dur_reg);
    assign end_time  = end_sum[TIME_W] ? TIME_MAX : end_sum[TIME_W-1:0];
    assign count_inc = (task_count_reg == TIME_MAX) ? TIME_MAX : task_count_reg + 1'b1;

    always_comb
    begin
        wr.load     = do_load;
        wr.set_free = commit;
        wr.weight   = in_weight;
        wr.free_val = end_time;
    end

    always_comb
    begin
        tok[0]       = '0;
        tok[0].valid = start_reg;
        tok[0].t0    = t0_reg;
        ai[0]        = '0;
        bi[0]        = '0;
    end

    for (genvar g = 0; g < NUM_SERVERS; g++)
    begin : g_cell
        assign active[g] = (CNT_W'(g) < pool);
        assign sel[g]    = do_load ? (CNT_W'(g) == CNT_W'(in_slot)) :
                                     (commit && (fin_idx_reg == IDX_W'(g)));

        mwsa_cell #(
            .IDX_W (IDX_W),
            .IDX   (g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .active  (active[g]),
            .wr_sel  (sel[g]),
            .wr      (wr),
            .tok_in  (tok[g]),
            .ai_in   (ai[g]),
            .bi_in   (bi[g]),
            .tok_out (tok[g+1]),
            .ai_out  (ai[g+1]),
            .bi_out  (bi[g+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cfg_reg        <= CFG_RST_VAL;
            start_reg      <= 1'b0;
            t0_reg         <= '0;
            dur_reg        <= '0;
            task_count_reg <= '0;
            last_start_reg <= '0;
            fin_t_reg      <= '0;
            fin_idx_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
        end
        else
        begin
            start_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                cfg_reg <= cfg_data;
            end
            if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (do_load)
                    begin
                        task_count_reg <= '0;
                        last_start_reg <= '0;
                    end
                    else if (s_accept && in_cmd)
                    begin
                        start_reg <= 1'b1;
                        t0_reg    <= t0_next;
                        dur_reg   <= in_dur;
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (tok[NUM_SERVERS].valid)
                    begin
                        fin_t_reg   <= tok[NUM_SERVERS].any ? tok[NUM_SERVERS].t0 :
                                                              tok[NUM_SERVERS].e;
                        fin_idx_reg <= tok[NUM_SERVERS].any ? ai[NUM_SERVERS] :
                                                              bi[NUM_SERVERS];
                        state_reg   <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (commit)
                    begin
                        m_tvalid_reg   <= 1'b1;
                        m_tdata_reg    <= {4'b0000, fin_t_reg, 4'(fin_idx_reg)};
                        last_start_reg <= fin_t_reg;
                        task_count_reg <= count_inc;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: sv/mwsa_chk.sv
// Port checker for the min-weight server assigner, bound to the top level.
// Watches the request and result handshakes only; no package dependency.
module mwsa_chk
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);

    // A task request blocks further requests until its search is done.
    a_task_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser[0] |=> !s_tready)
        else $error("request taken right after a task request");

    // A load request never blocks the input side.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tuser[0] |=> s_tready)
        else $error("input stalled after a load request");

    // A new result only appears when the input side was busy with a task.
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without a task in progress");

    // A stalled result holds its data.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind min_weight_server_assigner mwsa_chk u_mwsa_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
